### design/vcrib_pkg.sv
// ----------------------------------------------------------------------------
// vcrib_pkg
// Shared widths, operation codes, register numbers and the mode decoder
// for the video chip register and raster interrupt block.
// ----------------------------------------------------------------------------
`default_nettype none

package vcrib_pkg;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 8;
    localparam int LINE_W  = 9;
    localparam int OP_W    = 2;
    localparam int MODE_W  = 3;
    localparam int SBANK_W = 3;
    localparam int CBANK_W = 4;
    localparam int SRC_W   = 4;
    localparam int DEPTH   = 2 ** ADDR_W;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LINE  = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_CTRL1  = 6'h11;
    localparam logic [ADDR_W-1:0] ADDR_RASTER = 6'h12;
    localparam logic [ADDR_W-1:0] ADDR_CTRL2  = 6'h16;
    localparam logic [ADDR_W-1:0] ADDR_MEMPTR = 6'h18;
    localparam logic [ADDR_W-1:0] ADDR_IRQ    = 6'h19;

    localparam logic [SRC_W-1:0] IRQ_RASTER = 4'h1;

    localparam logic [MODE_W-1:0] MODE_TEXT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MC_TEXT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BITMAP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MC_BITMAP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN   = 3'd4;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    // bits: {ctrl1[6], ctrl1[5], ctrl2[4]}
    function automatic logic [MODE_W-1:0] decode_mode(input logic [2:0] bits);
        logic [MODE_W-1:0] m;
        case (bits)
            3'b000:  m = MODE_TEXT;
            3'b001:  m = MODE_MC_TEXT;
            3'b010:  m = MODE_BITMAP;
            3'b011:  m = MODE_MC_BITMAP;
            default: m = MODE_UNKNOWN;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### design/vcrib_regfile.sv
// ----------------------------------------------------------------------------
// vcrib_regfile
// 64 x 8 register storage: synchronous memory with registered read, plus
// per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module vcrib_regfile
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire vcrib_pkg::ram_req_t            req,
    output logic [vcrib_pkg::DATA_W-1:0]        rd_data
);

    logic [vcrib_pkg::DATA_W-1:0] entry_mem [vcrib_pkg::DEPTH];
    logic [vcrib_pkg::DEPTH-1:0]  valid_reg;
    logic [vcrib_pkg::DATA_W-1:0] rd_q_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= entry_mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    // an entry never written reads as zero
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

`ifndef SYNTHESIS
    a_unwritten_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req.rd_en && !valid_reg[req.addr]) |=> (rd_data == '0))
        else $error("unwritten entry read nonzero");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> valid_reg[$past(req.addr)])
        else $error("written entry not marked valid");

    a_read_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !req.rd_en |=> $stable(rd_data))
        else $error("read data moved without a read");
`endif

endmodule

`default_nettype wire

### design/video_chip_register_irq_block_unit.sv
// ----------------------------------------------------------------------------
// video_chip_register_irq_block_unit
// Register side of a raster video chip: 64 byte registers, raster compare
// interrupt, bank and display mode decode.
// ----------------------------------------------------------------------------
// Pipeline: input transfer, memory read beside stage 1, then output register.
// Throughput: one transfer per cycle unless a held output stalls stage 1; the
// register memory's single port takes one read or write per item.
// Reset: all control and side registers clear at once; register memory
// entries read zero until written (per-entry valid bits, no clearing pass).
`default_nettype none

module video_chip_register_irq_block_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [vcrib_pkg::OP_W-1:0]        op,
    input  wire logic [vcrib_pkg::ADDR_W-1:0]      reg_address,
    input  wire logic [vcrib_pkg::DATA_W-1:0]      write_data,
    input  wire logic [vcrib_pkg::LINE_W-1:0]      raster_line,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [vcrib_pkg::DATA_W-1:0]           read_data,
    output logic                                   irq_active,
    output logic [vcrib_pkg::MODE_W-1:0]           display_mode,
    output logic [vcrib_pkg::SBANK_W-1:0]          screen_bank,
    output logic [vcrib_pkg::CBANK_W-1:0]          char_bank
);

    // ------------------------------------------------------------------
    // Side state kept in flops; the byte registers live in the memory.
    // ------------------------------------------------------------------
    logic [vcrib_pkg::LINE_W-1:0]  compare_reg,  compare_next;
    logic [vcrib_pkg::DATA_W-1:0]  pending_reg,  pending_next;
    logic [vcrib_pkg::SRC_W-1:0]   enable_reg,   enable_next;
    logic [vcrib_pkg::SBANK_W-1:0] sbank_reg,    sbank_next;
    logic [vcrib_pkg::CBANK_W-1:0] cbank_reg,    cbank_next;
    // shadow of the mode bits: ctrl1[6:5] and ctrl2[4]
    logic [1:0]                    ctrl1_mode_reg, ctrl1_mode_next;
    logic                          ctrl2_mode_reg, ctrl2_mode_next;

    // stage 1: memory read in flight
    logic                          s1_valid_reg;
    logic [vcrib_pkg::DATA_W-1:0]  s1_mask_reg;
    logic [vcrib_pkg::DATA_W-1:0]  s1_byte_reg;
    logic                          s1_irq_reg;
    logic [vcrib_pkg::MODE_W-1:0]  s1_mode_reg;
    logic [vcrib_pkg::SBANK_W-1:0] s1_sbank_reg;
    logic [vcrib_pkg::CBANK_W-1:0] s1_cbank_reg;

    // output register
    logic                          out_valid_reg;
    logic [vcrib_pkg::DATA_W-1:0]  rdata_reg;
    logic                          irq_reg;
    logic [vcrib_pkg::MODE_W-1:0]  mode_reg;
    logic [vcrib_pkg::SBANK_W-1:0] obank_s_reg;
    logic [vcrib_pkg::CBANK_W-1:0] obank_c_reg;

    logic                          in_xfer;
    logic                          s1_advance;
    logic                          is_read, is_write, is_line;
    logic                          raster_hit;
    logic [vcrib_pkg::SRC_W-1:0]   src_flags;
    logic [vcrib_pkg::DATA_W-1:0]  mask_next;
    logic [vcrib_pkg::DATA_W-1:0]  byte_next;
    logic [vcrib_pkg::DATA_W-1:0]  mem_rdata;
    vcrib_pkg::ram_req_t           ram_req;

    // ------------------------------------------------------------------
    // Handshake: stage 1 moves on whenever the output register is empty
    // or its result is taken; the input stalls only behind a held stage 1.
    // ------------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_xfer    = in_valid && !in_stall;

    assign is_read  = (op == vcrib_pkg::OP_READ);
    assign is_write = (op == vcrib_pkg::OP_WRITE);
    assign is_line  = (op == vcrib_pkg::OP_LINE);

    // Memory access: issue the read (or write) on the transfer cycle only,
    // so the registered read data holds while stage 1 is stalled.
    always_comb
    begin
        ram_req.wr_en = in_xfer && is_write;
        ram_req.rd_en = in_xfer && is_read;
        ram_req.addr  = reg_address;
        ram_req.wdata = write_data;
    end

    vcrib_regfile u_regfile
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Side effects and read overrides, all resolved on the transfer cycle.
    // ------------------------------------------------------------------
    assign raster_hit = is_line && (compare_reg == raster_line);
    assign src_flags  = pending_reg[vcrib_pkg::SRC_W-1:0] | vcrib_pkg::IRQ_RASTER;

    always_comb
    begin
        compare_next    = compare_reg;
        pending_next    = pending_reg;
        enable_next     = enable_reg;
        sbank_next      = sbank_reg;
        cbank_next      = cbank_reg;
        ctrl1_mode_next = ctrl1_mode_reg;
        ctrl2_mode_next = ctrl2_mode_reg;
        mask_next       = '0;
        byte_next       = '0;

        if (is_read)
        begin
            mask_next = '1;
            case (reg_address)
                vcrib_pkg::ADDR_CTRL1:
                begin
                    // bit 7 shows the live beam line bit 8
                    mask_next = 8'h7f;
                    byte_next = {raster_line[8], 7'b0};
                end
                vcrib_pkg::ADDR_RASTER:
                begin
                    mask_next = '0;
                    byte_next = raster_line[7:0];
                end
                vcrib_pkg::ADDR_IRQ:
                begin
                    // read-to-clear of the pending flags
                    mask_next    = '0;
                    byte_next    = pending_reg;
                    pending_next = '0;
                end
                default:
                begin
                    mask_next = '1;
                end
            endcase
        end
        else if (is_write)
        begin
            case (reg_address)
                vcrib_pkg::ADDR_CTRL1:
                begin
                    compare_next    = {write_data[7], compare_reg[7:0]};
                    ctrl1_mode_next = write_data[6:5];
                end
                vcrib_pkg::ADDR_RASTER:
                begin
                    compare_next = {compare_reg[8], write_data};
                end
                vcrib_pkg::ADDR_CTRL2:
                begin
                    ctrl2_mode_next = write_data[4];
                end
                vcrib_pkg::ADDR_MEMPTR:
                begin
                    sbank_next = write_data[3:1];
                    cbank_next = write_data[7:4];
                end
                vcrib_pkg::ADDR_IRQ:
                begin
                    enable_next = write_data[3:0];
                end
                default:
                begin
                    compare_next = compare_reg;
                end
            endcase
        end
        else if (raster_hit)
        begin
            // old summary bit drops; re-evaluate it against the enable mask
            pending_next = {(|(src_flags & enable_reg)), 3'b0, src_flags};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg    <= '0;
            pending_reg    <= '0;
            enable_reg     <= '0;
            sbank_reg      <= '0;
            cbank_reg      <= '0;
            ctrl1_mode_reg <= '0;
            ctrl2_mode_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            compare_reg    <= compare_next;
            pending_reg    <= pending_next;
            enable_reg     <= enable_next;
            sbank_reg      <= sbank_next;
            cbank_reg      <= cbank_next;
            ctrl1_mode_reg <= ctrl1_mode_next;
            ctrl2_mode_reg <= ctrl2_mode_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the post-step status beside the pending memory read.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mask_reg  <= mask_next;
            s1_byte_reg  <= byte_next;
            s1_irq_reg   <= pending_next[7];
            s1_mode_reg  <= vcrib_pkg::decode_mode({ctrl1_mode_next, ctrl2_mode_next});
            s1_sbank_reg <= sbank_next;
            s1_cbank_reg <= cbank_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: merge memory data with the override byte.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            rdata_reg   <= (mem_rdata & s1_mask_reg) | s1_byte_reg;
            irq_reg     <= s1_irq_reg;
            mode_reg    <= s1_mode_reg;
            obank_s_reg <= s1_sbank_reg;
            obank_c_reg <= s1_cbank_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign irq_active   = irq_reg;
    assign display_mode = mode_reg;
    assign screen_bank  = obank_s_reg;
    assign char_bank    = obank_c_reg;

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty stage 1");

    a_irq_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_read && (reg_address == vcrib_pkg::ADDR_IRQ)) |=>
        (pending_reg == '0))
        else $error("pending flags not cleared by read");

    a_pending_gap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg[6:4] == 3'b0)
        else $error("unused pending bits set");

    a_enable_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_write && (reg_address == vcrib_pkg::ADDR_IRQ)) |=>
        (enable_reg == $past(write_data[3:0])))
        else $error("enable mask not updated");
`endif

endmodule

`default_nettype wire
